### rtl/blowfish_block_cipher_top_defines.svh
// ----------------------------------------------------------------------------
// Blowfish block cipher assertion macros
// Shared concurrent assertion forms for the cipher RTL.
// ----------------------------------------------------------------------------
`ifndef BLOWFISH_BLOCK_CIPHER_TOP_DEFINES_SVH
`define BLOWFISH_BLOCK_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// Blowfish block cipher package
// Command codes and fixed table geometry for the cipher core.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // Command codes carried on in_func
  typedef enum logic [1:0] {
    FUNC_WR_P = 2'd0,
    FUNC_WR_S = 2'd1,
    FUNC_ENC  = 2'd2,
    FUNC_DEC  = 2'd3
  } func_t;

  // P-array geometry
  localparam int unsigned P_WORDS = 18;
  localparam int unsigned P_IDX_W = 5;

  // Whitening entries of the P-array
  localparam logic [P_IDX_W-1:0] P_LWHITE = 5'd17;
  localparam logic [P_IDX_W-1:0] P_RWHITE = 5'd16;

  // S-box geometry: four boxes of 256 words
  localparam int unsigned SBOX_NUM   = 4;
  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned SBOX_AW    = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_W    = 64;

endpackage

### rtl/blowfish_block_cipher_top.sv
// ----------------------------------------------------------------------------
// Blowfish block cipher top level
// Loadable-table 64-bit Feistel cipher, one round per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   in_func selects: write P word, write S word, encrypt or decrypt.
//   Table writes finish in the accept cycle; busy stays low and no result
//   is produced. A P write with index 18 or above is dropped.
//   Encrypt/decrypt raises busy for the whole run, one Feistel round per
//   cycle. out_valid rises at the edge that drops busy, stays high for
//   exactly one cycle, and the result is taken at the edge that ends it.
//   A new transaction may be accepted at the edge that ends the result
//   cycle; none is taken while busy is high. The pace of blocks is set by
//   the round loop through the four S-box RAMs: each round needs the
//   previous round's read data to form the next read address.
//   The receiver cannot stall; out_valid is a one-cycle strobe.
//   Reset clears the sequencer and the strobe only; the P-array and S-boxes
//   hold no reset value and must be loaded before the first block.
//   Decryption runs the same round datapath with the key order reversed.
// ----------------------------------------------------------------------------
`include "blowfish_block_cipher_top_defines.svh"

module blowfish_block_cipher_top #(
  parameter int unsigned ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_table_index,
  input  logic [31:0] in_table_word,
  input  logic [63:0] in_data_block,
  output logic        out_valid,
  output logic [63:0] out_result_block,
  output logic        out_was_decrypt
);

  localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);
  localparam logic [bfc_pkg::P_IDX_W-1:0] DEC_BASE = bfc_pkg::P_IDX_W'(ROUNDS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                         state_r;
  logic [RND_W-1:0]               rnd_r;
  logic                           dec_r;
  logic [bfc_pkg::WORD_W-1:0]     xl_r;
  logic [bfc_pkg::WORD_W-1:0]     xr_r;
  logic [bfc_pkg::WORD_W-1:0]     xl_nxt;
  logic [bfc_pkg::WORD_W-1:0]     xr_nxt;
  logic                           out_valid_r;
  logic [bfc_pkg::BLOCK_W-1:0]    out_block_r;
  logic                           out_dec_r;

  // P-array in flops, no reset
  logic [bfc_pkg::WORD_W-1:0]     p_r [bfc_pkg::P_WORDS];

  logic                           accept;
  logic                           acc_cipher;
  logic                           acc_dec;
  logic                           last_rnd;
  logic [bfc_pkg::P_IDX_W-1:0]    key_sel;
  logic [bfc_pkg::WORD_W-1:0]     key_word;
  logic [bfc_pkg::WORD_W-1:0]     wl_word;
  logic [bfc_pkg::WORD_W-1:0]     wr_word;
  logic [bfc_pkg::SBOX_NUM-1:0][bfc_pkg::WORD_W-1:0] sbox_rd;
  logic [bfc_pkg::WORD_W-1:0]     f_out;
  logic [bfc_pkg::WORD_W-1:0]     new_r;

  // P index for round j: plain order on encrypt, reversed on decrypt
  function automatic logic [bfc_pkg::P_IDX_W-1:0] key_idx(
    input logic [bfc_pkg::P_IDX_W-1:0] j,
    input logic                        dec
  );
    logic [bfc_pkg::P_IDX_W-1:0] k;
    if (!dec) begin
      k = j;
    end else if (j == '0) begin
      k = bfc_pkg::P_LWHITE;
    end else if (j == bfc_pkg::P_IDX_W'(1)) begin
      k = bfc_pkg::P_RWHITE;
    end else begin
      k = DEC_BASE - j;
    end
    return k;
  endfunction

  assign accept     = start && (state_r == ST_IDLE);
  assign acc_cipher = accept && (in_func == bfc_pkg::FUNC_ENC || in_func == bfc_pkg::FUNC_DEC);
  assign acc_dec    = (in_func == bfc_pkg::FUNC_DEC);
  assign last_rnd   = (rnd_r == RND_LAST);

  // Key for the round about to be addressed
  always_comb begin
    if (state_r == ST_RUN) begin
      key_sel = key_idx(bfc_pkg::P_IDX_W'(rnd_r) + bfc_pkg::P_IDX_W'(1), dec_r);
    end else begin
      key_sel = key_idx('0, acc_dec);
    end
  end
  assign key_word = p_r[key_sel];

  // Whitening words: fixed entries chosen by direction
  assign wl_word = dec_r ? p_r[0] : p_r[bfc_pkg::P_LWHITE];
  assign wr_word = dec_r ? p_r[1] : p_r[bfc_pkg::P_RWHITE];

  // Round function on the registered S-box reads
  assign f_out = ((sbox_rd[0] + sbox_rd[1]) ^ sbox_rd[2]) + sbox_rd[3];
  assign new_r = xr_r ^ f_out;

  // Next halves; xl_nxt also addresses the S-box RAMs
  always_comb begin
    xl_nxt = xl_r;
    xr_nxt = xr_r;
    if (state_r == ST_RUN) begin
      xl_nxt = new_r ^ key_word;
      xr_nxt = xl_r;
    end else if (acc_cipher) begin
      xl_nxt = in_data_block[63:32] ^ key_word;
      xr_nxt = in_data_block[31:0];
    end
  end

  // S-box banks: one write port (table load), one read port (round)
  for (genvar g = 0; g < bfc_pkg::SBOX_NUM; g++) begin : g_sbox
    logic [bfc_pkg::WORD_W-1:0] mem [bfc_pkg::SBOX_DEPTH];
    logic                       we;
    logic [bfc_pkg::SBOX_AW-1:0] raddr;
    logic [bfc_pkg::WORD_W-1:0] rd_r;

    assign we = accept && (in_func == bfc_pkg::FUNC_WR_S) &&
                (in_table_index[9:8] == 2'(g));
    assign raddr = xl_nxt[bfc_pkg::WORD_W-1-8*g -: 8];

    always_ff @(posedge clk) begin
      if (we) begin
        mem[in_table_index[7:0]] <= in_table_word;
      end
      rd_r <= mem[raddr];
    end

    assign sbox_rd[g] = rd_r;
  end

  // P-array load
  always_ff @(posedge clk) begin
    if (accept && in_func == bfc_pkg::FUNC_WR_P &&
        in_table_index < 10'(bfc_pkg::P_WORDS)) begin
      p_r[in_table_index[bfc_pkg::P_IDX_W-1:0]] <= in_table_word;
    end
  end

  // Round sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      xl_r        <= xl_nxt;
      xr_r        <= xr_nxt;
      case (state_r)
        ST_IDLE: begin
          if (acc_cipher) begin
            state_r <= ST_RUN;
            rnd_r   <= '0;
            dec_r   <= acc_dec;
          end
        end
        ST_RUN: begin
          if (last_rnd) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            out_block_r <= {xl_r ^ wl_word, new_r ^ wr_word};
            out_dec_r   <= dec_r;
          end else begin
            rnd_r <= rnd_r + RND_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r == ST_RUN);
  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;
  assign out_was_decrypt  = out_dec_r;

  // Checks
  `BFC_ASSERT_NEXT(a_cipher_runs, clk, rst_n, acc_cipher, busy, "cipher transaction did not start")
  `BFC_ASSERT_NEXT(a_write_no_run, clk, rst_n, accept && !acc_cipher, !busy && !out_valid, "table write started a run")
  `BFC_ASSERT_NOW(a_result_after_last, clk, rst_n, out_valid, $past(busy) && $past(last_rnd), "result without final round")
  `BFC_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Blowfish block cipher testbench
// Loads the P-array and all four S-boxes, runs directed corner blocks, then a
// random mix of encrypts, decrypts and table rewrites. A clocked driver feeds
// transactions from a queue while an in-bench cipher model predicts every
// output block; a clocked monitor checks each result strobe against it.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS         = 16;
  localparam int unsigned ITEM_TARGET    = 1450;
  localparam int unsigned PHASE_LEN      = 60;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = ROUNDS + 8;

  // One command transaction plus the sender idle rate while it waits
  typedef struct {
    bfc_pkg::func_t func;
    logic [9:0]     tbl_idx;
    logic [31:0]    tbl_word;
    logic [63:0]    blk;
    int unsigned    idle_pct;
  } cipher_cmd_t;

  // One predicted output block
  typedef struct {
    logic [63:0] blk;
    logic        dec;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = bfc_pkg::FUNC_WR_P;
  logic [9:0]  in_table_index = '0;
  logic [31:0] in_table_word = '0;
  logic [63:0] in_data_block = '0;
  logic        out_valid;
  logic [63:0] out_result_block;
  logic        out_was_decrypt;

  // Model copy of the key tables
  logic [31:0] subkey_mem [bfc_pkg::P_WORDS];
  logic [31:0] sbox_mem   [bfc_pkg::SBOX_NUM*bfc_pkg::SBOX_DEPTH];

  cipher_cmd_t cmd_queue[$];
  cipher_out_t expected_blocks[$];
  cipher_cmd_t cur_cmd;

  int unsigned total_cmds;
  int unsigned accepted_cnt;
  int unsigned p_write_cnt;
  int unsigned p_drop_cnt;
  int unsigned s_write_cnt;
  int unsigned enc_cnt;
  int unsigned dec_cnt;
  int unsigned result_cnt;
  int unsigned err_cnt;
  int unsigned stall_cycles;

  blowfish_block_cipher_top #(
    .ROUNDS(ROUNDS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_table_index  (in_table_index),
    .in_table_word   (in_table_word),
    .in_data_block   (in_data_block),
    .out_valid       (out_valid),
    .out_result_block(out_result_block),
    .out_was_decrypt (out_was_decrypt)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Round function: ((S0[a] + S1[b]) ^ S2[c]) + S3[d]
  function automatic logic [31:0] feistel_f(input logic [31:0] x);
    logic [31:0] h;
    h = sbox_mem[{2'd0, x[31:24]}] + sbox_mem[{2'd1, x[23:16]}];
    h = h ^ sbox_mem[{2'd2, x[15:8]}];
    return h + sbox_mem[{2'd3, x[7:0]}];
  endfunction

  function automatic logic [63:0] feistel_encrypt(input logic [63:0] blk);
    logic [31:0] xl;
    logic [31:0] xr;
    logic [31:0] tmp;
    xl = blk[63:32];
    xr = blk[31:0];
    for (int i = 0; i < ROUNDS; i++) begin
      xl  = xl ^ subkey_mem[i];
      xr  = xr ^ feistel_f(xl);
      tmp = xl;
      xl  = xr;
      xr  = tmp;
    end
    // undo last swap, then whiten
    return {xr ^ subkey_mem[bfc_pkg::P_LWHITE], xl ^ subkey_mem[bfc_pkg::P_RWHITE]};
  endfunction

  function automatic logic [63:0] feistel_decrypt(input logic [63:0] blk);
    logic [31:0] xl;
    logic [31:0] xr;
    logic [31:0] tmp;
    xl = blk[63:32] ^ subkey_mem[bfc_pkg::P_LWHITE];
    xr = blk[31:0] ^ subkey_mem[bfc_pkg::P_RWHITE];
    for (int i = ROUNDS - 1; i >= 0; i--) begin
      if (i != ROUNDS - 1) begin
        tmp = xl;
        xl  = xr;
        xr  = tmp;
      end
      xr = xr ^ feistel_f(xl);
      xl = xl ^ subkey_mem[i];
    end
    return {xl, xr};
  endfunction

  // Queue a transaction; idle rate cycles through phases:
  // none, sender idle 63%, none (receiver cannot stall), sender idle 20%
  task automatic queue_cmd(input bfc_pkg::func_t f, input logic [9:0] idx,
                           input logic [31:0] word, input logic [63:0] blk);
    cipher_cmd_t c;
    c.func     = f;
    c.tbl_idx  = idx;
    c.tbl_word = word;
    c.blk      = blk;
    case ((cmd_queue.size() / PHASE_LEN) % 4)
      1:       c.idle_pct = 63;
      3:       c.idle_pct = 20;
      default: c.idle_pct = 0;
    endcase
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: present queued transactions, update the model on acceptance
  always @(posedge clk) begin : drive_proc
    logic        next_start;
    cipher_out_t exp_item;
    next_start = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        accepted_cnt++;
        case (cur_cmd.func)
          bfc_pkg::FUNC_WR_P: begin
            if (cur_cmd.tbl_idx < bfc_pkg::P_WORDS) begin
              subkey_mem[cur_cmd.tbl_idx] = cur_cmd.tbl_word;
              p_write_cnt++;
            end else begin
              p_drop_cnt++;
            end
          end
          bfc_pkg::FUNC_WR_S: begin
            sbox_mem[cur_cmd.tbl_idx] = cur_cmd.tbl_word;
            s_write_cnt++;
          end
          bfc_pkg::FUNC_ENC: begin
            exp_item = '{feistel_encrypt(cur_cmd.blk), 1'b0};
            expected_blocks.insert(expected_blocks.size(), exp_item);
            enc_cnt++;
          end
          default: begin
            exp_item = '{feistel_decrypt(cur_cmd.blk), 1'b1};
            expected_blocks.insert(expected_blocks.size(), exp_item);
            dec_cnt++;
          end
        endcase
      end
      if (start && busy) begin
        // hold the offered transaction until taken
        next_start = 1'b1;
      end else if (cmd_queue.size() != 0) begin
        if ($urandom_range(99) >= cmd_queue[0].idle_pct) begin
          cur_cmd        = cmd_queue.pop_front();
          in_func        <= cur_cmd.func;
          in_table_index <= cur_cmd.tbl_idx;
          in_table_word  <= cur_cmd.tbl_word;
          in_data_block  <= cur_cmd.blk;
          next_start     = 1'b1;
        end else begin
          // idle cycle: scramble the payload
          in_table_word <= $urandom;
          in_data_block <= rand64();
        end
      end
    end
    start <= next_start;
  end

  // Monitor: check each result strobe against the oldest prediction
  always @(posedge clk) begin : check_proc
    cipher_out_t exp_out;
    if (rst_n && out_valid) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result: result_block %h was_decrypt %b",
               out_result_block, out_was_decrypt);
        err_cnt++;
      end else begin
        exp_out = expected_blocks.pop_front();
        result_cnt++;
        if (out_result_block !== exp_out.blk) begin
          $error("result_block mismatch: expected %h, actual %h",
                 exp_out.blk, out_result_block);
          err_cnt++;
        end
        if (out_was_decrypt !== exp_out.dec) begin
          $error("was_decrypt mismatch: expected %b, actual %b",
                 exp_out.dec, out_was_decrypt);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: cycles without any transaction or result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus and end of test
  initial begin
    int unsigned counted;
    int unsigned roll;
    logic [63:0] corner_blk [6];

    // load every S-box word, extremes at both ends
    for (int i = 0; i < bfc_pkg::SBOX_NUM*bfc_pkg::SBOX_DEPTH; i++) begin
      queue_cmd(bfc_pkg::FUNC_WR_S, 10'(i),
                (i == 0) ? 32'h0 :
                (i == bfc_pkg::SBOX_NUM*bfc_pkg::SBOX_DEPTH - 1) ? 32'hFFFF_FFFF :
                $urandom,
                rand64());
    end
    // load every P word
    for (int i = 0; i < bfc_pkg::P_WORDS; i++) begin
      queue_cmd(bfc_pkg::FUNC_WR_P, 10'(i),
                (i == 0) ? 32'hFFFF_FFFF : (i == bfc_pkg::P_WORDS - 1) ? 32'h0 : $urandom,
                rand64());
    end

    // out-of-range P writes must be dropped
    queue_cmd(bfc_pkg::FUNC_WR_P, 10'd18, $urandom, rand64());
    queue_cmd(bfc_pkg::FUNC_WR_P, 10'd31, 32'hFFFF_FFFF, rand64());
    queue_cmd(bfc_pkg::FUNC_WR_P, 10'h3FF, $urandom, rand64());

    // corner blocks through both directions
    corner_blk = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
                   64'hFFFF_FFFF_0000_0000, 64'h5555_5555_AAAA_AAAA,
                   64'h0123_4567_89AB_CDEF};
    foreach (corner_blk[i]) begin
      queue_cmd(bfc_pkg::FUNC_ENC, 10'($urandom), $urandom, corner_blk[i]);
      queue_cmd(bfc_pkg::FUNC_DEC, 10'($urandom), $urandom, corner_blk[i]);
    end

    // rewrite a whitening word and use it at once
    queue_cmd(bfc_pkg::FUNC_WR_P, 10'(bfc_pkg::P_RWHITE), 32'hFFFF_FFFF, rand64());
    queue_cmd(bfc_pkg::FUNC_ENC, 10'($urandom), $urandom, 64'h0);
    queue_cmd(bfc_pkg::FUNC_DEC, 10'($urandom), $urandom, 64'h0);

    // random mix: mostly blocks, with table rewrites in between
    counted = cmd_queue.size() - 3;
    while (counted < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        queue_cmd(bfc_pkg::FUNC_ENC, 10'($urandom), $urandom, rand64());
        counted++;
      end else if (roll < 70) begin
        queue_cmd(bfc_pkg::FUNC_DEC, 10'($urandom), $urandom, rand64());
        counted++;
      end else if (roll < 80) begin
        queue_cmd(bfc_pkg::FUNC_WR_P, 10'($urandom_range(bfc_pkg::P_WORDS - 1)),
                  $urandom, rand64());
        counted++;
      end else if (roll < 85) begin
        queue_cmd(bfc_pkg::FUNC_WR_P, 10'($urandom_range(1023, bfc_pkg::P_WORDS)),
                  $urandom, rand64());
      end else begin
        queue_cmd(bfc_pkg::FUNC_WR_S, 10'($urandom), $urandom, rand64());
        counted++;
      end
    end
    total_cmds = cmd_queue.size();

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every transaction and every result
    while (accepted_cnt < total_cmds || expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d P writes (%0d dropped), %0d S writes,",
             accepted_cnt, p_write_cnt, p_drop_cnt, s_write_cnt);
    $display("%0d encrypts and %0d decrypts, %0d results checked, %0d errors",
             enc_cnt, dec_cnt, result_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
